// ----- rtl/core/plin_pkg.sv -----
// Shared types, status codes and sizing constants for the piecewise linear interpolator.
package plin_pkg;

    localparam int CAPACITY_DEFAULT = 16;
    localparam int COORD_W          = 32;
    localparam int STATUS_W         = 3;
    localparam int ALU_W            = COORD_W + 2;
    localparam int DIV_STEPS        = COORD_W;
    localparam int DIV_CNT_W        = $clog2(DIV_STEPS);

    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    localparam logic [STATUS_W-1:0] ST_EVAL    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_APPEND  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REPLACE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DUP     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd5;

    typedef struct packed {
        logic                      action;
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
    } in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] result_value;
        logic [STATUS_W-1:0]       status;
    } out_t;

endpackage

// ----- rtl/core/piecewise_linear_interpolator_top.sv -----
// Sequence: an empty-table request goes straight to the result load; an add or clamped evaluate
// first scans the breakpoints; an interpolating evaluate runs the scan, four add/sub steps,
// one multiply, 32 restoring division steps and a final add/sub.
// Throughput: one request at a time; ready is high only while idle, which follows the result load,
// and a held result stalls that load. One 34-bit add/sub unit serves all.
// Reset: rst_n is asynchronous, active low; it empties the table and drops any pending result.
module piecewise_linear_interpolator_top #(
    parameter int CAPACITY = plin_pkg::CAPACITY_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  plin_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output plin_pkg::out_t out_data
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CW    = plin_pkg::COORD_W;
    localparam int AW    = plin_pkg::ALU_W;
    localparam int DCW   = plin_pkg::DIV_CNT_W;

    // Sequencer codes
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SCAN = 4'd1;
    localparam logic [3:0] S_DX   = 4'd2;
    localparam logic [3:0] S_DD   = 4'd3;
    localparam logic [3:0] S_DY   = 4'd4;
    localparam logic [3:0] S_MAG  = 4'd5;
    localparam logic [3:0] S_MUL  = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    // Breakpoint store: one write port and one registered read port per array
    logic [CW-1:0] mem_x [CAPACITY];
    logic [CW-1:0] mem_y [CAPACITY];
    logic [CW-1:0] rd_x_reg, rd_y_reg;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic [CW-1:0] wr_x, wr_y;
    logic          wr_en;

    // Control state
    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [DCW-1:0]   div_cnt_reg, div_cnt_next;
    logic             out_valid_reg, out_valid_next;

    // Working registers (no reset needed)
    logic [CW-1:0]  x_reg, x_next;
    logic [CW-1:0]  y_reg, y_next;
    logic           act_reg, act_next;
    logic [CW-1:0]  prev_x_reg, prev_x_next;
    logic [CW-1:0]  prev_y_reg, prev_y_next;
    logic [CW-1:0]  x1_reg, x1_next;
    logic [CW-1:0]  y1_reg, y1_next;
    logic [CW-1:0]  dx_reg, dx_next;
    logic [CW-1:0]  dd_reg, dd_next;
    logic [CW-1:0]  mag_reg, mag_next;
    logic           neg_reg, neg_next;
    logic [CW-1:0]  rem_reg, rem_next;
    logic [CW-1:0]  quo_reg, quo_next;
    logic [CW-1:0]  res_val_reg, res_val_next;
    logic [plin_pkg::STATUS_W-1:0] res_st_reg, res_st_next;
    plin_pkg::out_t out_data_reg, out_data_next;

    // Shared add/sub unit
    logic [AW-1:0] alu_a, alu_b, alu_res;
    logic          alu_sub;

    logic          accept;
    logic          is_last;
    logic          is_le;
    logic          is_eq;
    logic [CW:0]   div_shift;

    function automatic logic [AW-1:0] sext(input logic [CW-1:0] v);
        return {{(AW - CW){v[CW-1]}}, v};
    endfunction

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign is_last   = (CNT_W'(pos_reg) + CNT_W'(1)) == n_reg;
    assign is_eq     = (alu_res == '0);
    assign is_le     = alu_res[AW-1] || is_eq;
    assign div_shift = {rem_reg, quo_reg[CW-1]};

    // Address the next entry while the current one is being compared
    assign rd_addr = (state_reg == S_SCAN) ? IDX_W'(pos_reg + IDX_W'(1)) : '0;

    assign alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + AW'(alu_sub);

    always_comb
    begin
        alu_a   = sext(x_reg);
        alu_b   = sext(rd_x_reg);
        alu_sub = 1'b1;
        unique case (state_reg)
            S_SCAN:
            begin
                alu_a = sext(x_reg);
                alu_b = sext(rd_x_reg);
            end
            S_DX:
            begin
                alu_a = sext(x_reg);
                alu_b = sext(prev_x_reg);
            end
            S_DD:
            begin
                alu_a = sext(x1_reg);
                alu_b = sext(prev_x_reg);
            end
            S_DY:
            begin
                alu_a = sext(y1_reg);
                alu_b = sext(prev_y_reg);
            end
            S_MAG:
            begin
                alu_a = neg_reg ? sext(prev_y_reg) : sext(y1_reg);
                alu_b = neg_reg ? sext(y1_reg) : sext(prev_y_reg);
            end
            S_DIV:
            begin
                alu_a = {{(AW - CW - 1){1'b0}}, div_shift};
                alu_b = {{(AW - CW){1'b0}}, dd_reg};
            end
            S_FIN:
            begin
                alu_a   = sext(prev_y_reg);
                alu_b   = {{(AW - CW){1'b0}}, quo_reg};
                alu_sub = neg_reg;
            end
            default:
            begin
                alu_a = sext(x_reg);
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        pos_next       = pos_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        act_next       = act_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        x1_next        = x1_reg;
        y1_next        = y1_reg;
        dx_next        = dx_reg;
        dd_next        = dd_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        res_val_next   = res_val_reg;
        res_st_next    = res_st_reg;
        out_data_next  = out_data_reg;
        wr_en          = 1'b0;
        wr_addr        = n_reg[IDX_W-1:0];
        wr_x           = x_reg;
        wr_y           = y_reg;

        // Drop the delivered result
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    x_next       = in_data.x_coord;
                    y_next       = in_data.y_coord;
                    act_next     = in_data.action;
                    pos_next     = '0;
                    res_val_next = '0;
                    if (n_reg == '0)
                    begin
                        state_next = S_DONE;
                        if (in_data.action == plin_pkg::ACT_EVAL)
                        begin
                            res_st_next = plin_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            wr_en       = 1'b1;
                            wr_addr     = '0;
                            wr_x        = in_data.x_coord;
                            wr_y        = in_data.y_coord;
                            n_next      = CNT_W'(1);
                            res_st_next = plin_pkg::ST_APPEND;
                        end
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (act_reg == plin_pkg::ACT_ADD)
                begin
                    if (is_eq)
                    begin
                        res_st_next = plin_pkg::ST_DUP;
                        state_next  = S_DONE;
                    end
                    else if (is_le)
                    begin
                        wr_en       = 1'b1;
                        wr_addr     = pos_reg;
                        res_st_next = plin_pkg::ST_REPLACE;
                        state_next  = S_DONE;
                    end
                    else if (is_last)
                    begin
                        state_next = S_DONE;
                        if (n_reg == CNT_W'(CAPACITY))
                        begin
                            res_st_next = plin_pkg::ST_FULL;
                        end
                        else
                        begin
                            wr_en       = 1'b1;
                            n_next      = n_reg + CNT_W'(1);
                            res_st_next = plin_pkg::ST_APPEND;
                        end
                    end
                    else
                    begin
                        pos_next = pos_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    res_st_next = plin_pkg::ST_EVAL;
                    if (is_le && (pos_reg != '0) && !is_eq)
                    begin
                        x1_next    = rd_x_reg;
                        y1_next    = rd_y_reg;
                        state_next = S_DX;
                    end
                    else if (is_le || is_last)
                    begin
                        // Clamp, exact hit or past the last breakpoint
                        res_val_next = rd_y_reg;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        prev_x_next = rd_x_reg;
                        prev_y_next = rd_y_reg;
                        pos_next    = pos_reg + IDX_W'(1);
                    end
                end
            end
            S_DX:
            begin
                dx_next    = alu_res[CW-1:0];
                state_next = S_DD;
            end
            S_DD:
            begin
                dd_next    = alu_res[CW-1:0];
                state_next = S_DY;
            end
            S_DY:
            begin
                neg_next   = alu_res[AW-1];
                state_next = S_MAG;
            end
            S_MAG:
            begin
                mag_next   = alu_res[CW-1:0];
                state_next = S_MUL;
            end
            S_MUL:
            begin
                // High half is below the divisor since dx never exceeds dd
                {rem_next, quo_next} = dx_reg * mag_reg;
                div_cnt_next         = '0;
                state_next           = S_DIV;
            end
            S_DIV:
            begin
                if (!alu_res[AW-1])
                begin
                    rem_next = alu_res[CW-1:0];
                end
                else
                begin
                    rem_next = div_shift[CW-1:0];
                end
                quo_next     = {quo_reg[CW-2:0], !alu_res[AW-1]};
                div_cnt_next = div_cnt_reg + DCW'(1);
                if (div_cnt_reg == DCW'(plin_pkg::DIV_STEPS - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                res_val_next = alu_res[CW-1:0];
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next.result_value = res_val_reg;
                    out_data_next.status       = res_st_reg;
                    out_valid_next             = 1'b1;
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= '0;
            pos_reg       <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            pos_reg       <= pos_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        act_reg      <= act_next;
        prev_x_reg   <= prev_x_next;
        prev_y_reg   <= prev_y_next;
        x1_reg       <= x1_next;
        y1_reg       <= y1_next;
        dx_reg       <= dx_next;
        dd_reg       <= dd_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        res_val_reg  <= res_val_next;
        res_st_reg   <= res_st_next;
        out_data_reg <= out_data_next;
    end

    // Breakpoint memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[wr_addr] <= wr_x;
            mem_y[wr_addr] <= wr_y;
        end
        rd_x_reg <= mem_x[rd_addr];
        rd_y_reg <= mem_y[rd_addr];
    end

endmodule

// ----- rtl/core/plin_checker.sv -----
// Port-level checker for the piecewise linear interpolator and its bind.
module plin_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input plin_pkg::in_t  in_data,
    input logic           out_valid,
    input logic           out_ready,
    input plin_pkg::out_t out_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed or dropped while stalled");

    // One request at a time: busy right after acceptance
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while previous one in flight");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status <= plin_pkg::ST_EMPTY))
        else $error("status code out of range");

    // Only an evaluation carries a non-zero value
    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != plin_pkg::ST_EVAL) |-> (out_data.result_value == '0))
        else $error("non-zero value on a non-evaluate result");

endmodule

bind piecewise_linear_interpolator_top plin_checker u_plin_checker (.*);
